// File: hdl/mtlsd_pkg.sv
// package for the multi-track level sync detector
// holds the track entry and result types, field positions and codes
// no dependencies
package mtlsd_pkg;

  localparam int NUM_TRACKS_DEF = 8;
  localparam int SEL_W          = 3;
  localparam int STAMP_W        = 64;
  localparam int LEVEL_W        = 32;
  localparam int STATUS_W       = 2;

  // input word layout
  localparam int IN_TA_LO    = 0;
  localparam int IN_TB_LO    = IN_TA_LO + SEL_W;
  localparam int IN_STAMP_LO = IN_TB_LO + SEL_W;
  localparam int IN_LEVEL_LO = IN_STAMP_LO + STAMP_W;
  localparam int IN_USED_W   = IN_LEVEL_LO + LEVEL_W;
  localparam int IN_DATA_W   = ((IN_USED_W + 7) / 8) * 8;

  // output word layout
  localparam int OUT_STATUS_LO = 0;
  localparam int OUT_OFFSET_LO = OUT_STATUS_LO + STATUS_W;
  localparam int OUT_USED_W    = OUT_OFFSET_LO + STAMP_W;
  localparam int OUT_DATA_W    = ((OUT_USED_W + 7) / 8) * 8;

  localparam logic FN_WRITE = 1'b0;
  localparam logic FN_QUERY = 1'b1;

  localparam logic [STATUS_W-1:0] ST_UNDEF = 2'd0;
  localparam logic [STATUS_W-1:0] ST_WHITE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BLACK = 2'd2;

  localparam logic [1:0] EDGE_UP   = 2'b01;
  localparam logic [1:0] EDGE_DOWN = 2'b10;

  localparam logic [LEVEL_W-1:0] NO_LEVEL = '1;

  typedef struct packed {
    logic [STATUS_W-1:0] state;
    logic [STAMP_W-1:0]  stamp;
    logic [LEVEL_W-1:0]  level;
  } entry_t;

  localparam int ENT_W = $bits(entry_t);

  localparam entry_t ENT_RESET = '{state: ST_UNDEF, stamp: '0, level: NO_LEVEL};

  typedef struct packed {
    logic   en;
    entry_t ent;
  } upd_t;

  typedef struct packed {
    logic [STATUS_W-1:0] track_status;
    logic                offset_valid;
    logic [STAMP_W-1:0]  offset_us;
  } res_t;

endpackage

// File: hdl/mtlsd_ram.sv
// generic ram, one write port and two registered read ports
// no dependencies
module mtlsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// File: hdl/mtlsd_eval.sv
// per-item evaluation: threshold crossing update and switch-time offset
// depends on mtlsd_pkg
module mtlsd_eval
  import mtlsd_pkg::*;
(
  input  logic               func,
  input  logic               a_ok,
  input  logic               b_ok,
  input  logic [STAMP_W-1:0] stamp,
  input  logic [LEVEL_W-1:0] level,
  input  logic [LEVEL_W-1:0] threshold,
  input  entry_t             ent_a,
  input  entry_t             ent_b,
  output upd_t               upd,
  output res_t               res
);

  logic [1:0] edg;

  always_comb begin
    edg          = {ent_a.level > threshold, level > threshold};
    upd.en       = (func == FN_WRITE) && a_ok;
    upd.ent      = ent_a;
    upd.ent.level = level;
    if (ent_a.level != NO_LEVEL) begin
      case (edg)
        EDGE_UP: begin
          upd.ent.state = ST_WHITE;
          upd.ent.stamp = stamp;
        end
        EDGE_DOWN: begin
          upd.ent.state = ST_BLACK;
          upd.ent.stamp = stamp;
        end
        default: begin
        end
      endcase
    end

    res.offset_valid = 1'b0;
    res.offset_us    = '0;
    if (func == FN_QUERY && a_ok && b_ok && ent_a.state == ent_b.state &&
        ent_a.state != ST_UNDEF) begin
      res.offset_valid = 1'b1;
      res.offset_us    = ent_a.stamp - ent_b.stamp;
    end

    if (!a_ok) begin
      res.track_status = ST_UNDEF;
    end else if (func == FN_WRITE) begin
      res.track_status = upd.ent.state;
    end else begin
      res.track_status = ent_a.state;
    end
  end

endmodule

// File: hdl/multi_track_level_sync_detector.sv
// top level of the multi-track level sync detector
// depends on mtlsd_pkg, mtlsd_ram and mtlsd_eval
//
// Usage:
//   in_*  : one word per item; in_tuser is the function (0 write a level
//           sample, 1 query two tracks).
//   out_* : exactly one result word per input word, in order.
//   cfg_* : writes the shared level threshold; always ready; the user is to
//           write it only while idle, which the block itself does not enforce.
// out_tvalid follows the input register and then the result register; one word
// per cycle is sustained while out_tready is high. The track table is read at
// accept time (two read ports of the table ram) and updated when the item moves
// to the output register; the last table write is forwarded to the next item.
// Reset clears the threshold and marks all tracks unwritten through per-track
// valid bits, so the table reads as undefined / no level right after reset,
// with no clearing pass.
// When the receiver stalls, the output word holds, the evaluation stage holds
// one more item, and in_tready drops until out_tready returns.
module multi_track_level_sync_detector
  import mtlsd_pkg::*;
#(
  parameter int NUM_TRACKS = NUM_TRACKS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [LEVEL_W-1:0]    cfg_data,   // level_threshold
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // track_sel, other_track_sel, stamp_us, level, zero pad
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tuser,   // func
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // track_status, offset_us, zero pad
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tuser   // offset_valid
);

  localparam int TRK_W = (NUM_TRACKS > 1) ? $clog2(NUM_TRACKS) : 1;

  logic [LEVEL_W-1:0]    thr_r;
  logic [NUM_TRACKS-1:0] vld_r;

  logic                  s1_vld_r;
  logic                  s1_func_r;
  logic [TRK_W-1:0]      s1_ia_r;
  logic [TRK_W-1:0]      s1_ib_r;
  logic                  s1_aok_r;
  logic                  s1_bok_r;
  logic [STAMP_W-1:0]    s1_stamp_r;
  logic [LEVEL_W-1:0]    s1_lvl_r;
  logic                  s1_avld_r;
  logic                  s1_bvld_r;

  logic                  byp_vld_r;
  logic [TRK_W-1:0]      byp_idx_r;
  entry_t                byp_ent_r;

  logic                  out_vld_r;
  res_t                  out_res_r;

  logic [SEL_W-1:0]      in_ta;
  logic [SEL_W-1:0]      in_tb;
  logic [TRK_W-1:0]      in_ia;
  logic [TRK_W-1:0]      in_ib;
  logic                  in_aok;
  logic                  in_bok;
  logic                  in_acc;
  logic                  out_free;
  logic                  s1_fire;

  entry_t                ram_a;
  entry_t                ram_b;
  entry_t                ent_a;
  entry_t                ent_b;
  upd_t                  upd;
  res_t                  res;

  assign cfg_ready = 1'b1;

  assign in_ta  = in_tdata[IN_TA_LO +: SEL_W];
  assign in_tb  = in_tdata[IN_TB_LO +: SEL_W];
  assign in_ia  = TRK_W'(in_ta);
  assign in_ib  = TRK_W'(in_tb);
  assign in_aok = 32'(in_ta) < 32'(NUM_TRACKS);
  assign in_bok = 32'(in_tb) < 32'(NUM_TRACKS);

  assign out_free  = !out_vld_r || out_tready;
  assign s1_fire   = s1_vld_r && out_free;
  assign in_tready = !s1_vld_r || out_free;
  assign in_acc    = in_tvalid && in_tready;

  mtlsd_ram #(
    .WIDTH (ENT_W),
    .DEPTH (NUM_TRACKS)
  ) u_ram (
    .clk     (clk),
    .we      (s1_fire && upd.en),
    .waddr   (s1_ia_r),
    .wdata   (upd.ent),
    .re      (in_acc),
    .raddr_a (in_ia),
    .raddr_b (in_ib),
    .rdata_a (ram_a),
    .rdata_b (ram_b)
  );

  always_comb begin
    if (byp_vld_r && byp_idx_r == s1_ia_r) begin
      ent_a = byp_ent_r;
    end else if (s1_avld_r) begin
      ent_a = ram_a;
    end else begin
      ent_a = ENT_RESET;
    end
    if (byp_vld_r && byp_idx_r == s1_ib_r) begin
      ent_b = byp_ent_r;
    end else if (s1_bvld_r) begin
      ent_b = ram_b;
    end else begin
      ent_b = ENT_RESET;
    end
  end

  mtlsd_eval u_eval (
    .func      (s1_func_r),
    .a_ok      (s1_aok_r),
    .b_ok      (s1_bok_r),
    .stamp     (s1_stamp_r),
    .level     (s1_lvl_r),
    .threshold (thr_r),
    .ent_a     (ent_a),
    .ent_b     (ent_b),
    .upd       (upd),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r     <= '0;
      vld_r     <= '0;
      s1_vld_r  <= 1'b0;
      byp_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        thr_r <= cfg_data;
      end
      if (in_tready) begin
        s1_vld_r <= in_tvalid;
      end
      if (out_free) begin
        out_vld_r <= s1_vld_r;
      end
      if (s1_fire && upd.en) begin
        vld_r[s1_ia_r] <= 1'b1;
        byp_vld_r      <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_func_r  <= in_tuser;
      s1_ia_r    <= in_ia;
      s1_ib_r    <= in_ib;
      s1_aok_r   <= in_aok;
      s1_bok_r   <= in_bok;
      s1_stamp_r <= in_tdata[IN_STAMP_LO +: STAMP_W];
      s1_lvl_r   <= in_tdata[IN_LEVEL_LO +: LEVEL_W];
      s1_avld_r  <= vld_r[in_ia];
      s1_bvld_r  <= vld_r[in_ib];
    end
    if (s1_fire && upd.en) begin
      byp_idx_r <= s1_ia_r;
      byp_ent_r <= upd.ent;
    end
    if (s1_fire) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_res_r.offset_valid;
  assign out_tdata  = OUT_DATA_W'({out_res_r.offset_us, out_res_r.track_status});

  // forwarded entry always belongs to a written track
  a_byp_written: assert property (@(posedge clk) disable iff (!rst_n)
    byp_vld_r |-> vld_r[byp_idx_r])
    else $error("bypass entry points at an unwritten track");

  // an offset is only reported for tracks in a defined state
  a_valid_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_res_r.offset_valid |-> out_res_r.track_status != ST_UNDEF)
    else $error("offset reported for an undefined track");

  // no offset value leaks out without the valid flag
  a_zero_offset: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_res_r.offset_valid |-> out_res_r.offset_us == '0)
    else $error("offset nonzero while not valid");

  // on a result stall the evaluation stage keeps its item and blocks new input
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r && out_vld_r && !out_tready |=> s1_vld_r && $stable(s1_ia_r))
    else $error("evaluation stage lost its item under stall");

endmodule

// File: verif/mtlsd_checker.sv
// checker for the multi-track level sync detector: watches the config, input
// and result channels, keeps its own track table and compares every result
// depends on mtlsd_pkg
module mtlsd_checker
  import mtlsd_pkg::*;
#(
  parameter int NUM_TRACKS = NUM_TRACKS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [LEVEL_W-1:0]    cfg_data,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tuser,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  out_tuser,
  output int                    error_count,
  output int                    outstanding,
  output int                    checked_count,
  output int                    offset_hits
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [LEVEL_W-1:0]  threshold;
  logic [STATUS_W-1:0] track_state  [NUM_TRACKS];
  logic [STAMP_W-1:0]  track_switch [NUM_TRACKS];
  logic [LEVEL_W-1:0]  track_level  [NUM_TRACKS];
  res_t                due_results  [$];

  task automatic report(string what, logic [STAMP_W-1:0] want, logic [STAMP_W-1:0] got);
    if (error_count < 40) begin
      $display("mismatch on %s: expected %h, got %h at %0t", what, want, got, $realtime);
    end
    error_count++;
  endtask

  task automatic step_tracks(input logic fn, input logic [SEL_W-1:0] ta,
                             input logic [SEL_W-1:0] tb, input logic [STAMP_W-1:0] stamp,
                             input logic [LEVEL_W-1:0] lvl, output res_t r);
    logic [1:0] crossing;
    bit         a_ok;
    bit         b_ok;
    r = '0;
    a_ok = ta < NUM_TRACKS;
    b_ok = tb < NUM_TRACKS;
    if (fn == FN_WRITE) begin
      if (a_ok) begin
        if (track_level[ta] != NO_LEVEL) begin
          crossing = '0;
          if (track_level[ta] > threshold) crossing |= EDGE_DOWN;
          if (lvl > threshold) crossing |= EDGE_UP;
          if (crossing == EDGE_UP || crossing == EDGE_DOWN) begin
            track_state[ta]  = (crossing == EDGE_UP) ? ST_WHITE : ST_BLACK;
            track_switch[ta] = stamp;
          end
        end
        track_level[ta] = lvl;
      end
    end else if (a_ok && b_ok && track_state[ta] == track_state[tb] &&
                 track_state[ta] != ST_UNDEF) begin
      r.offset_valid = 1'b1;
      r.offset_us    = track_switch[ta] - track_switch[tb];
    end
    if (a_ok) r.track_status = track_state[ta];
  endtask

  always @(posedge clk) begin
    res_t                want;
    logic [STATUS_W-1:0] got_status;
    logic [STAMP_W-1:0]  got_offset;
    if (!rst_n) begin
      threshold = '0;
      for (int i = 0; i < NUM_TRACKS; i++) begin
        track_state[i]  = ST_UNDEF;
        track_switch[i] = '0;
        track_level[i]  = NO_LEVEL;
      end
      due_results.delete();
      error_count   = 0;
      checked_count = 0;
      offset_hits   = 0;
      outstanding  <= 0;
    end else begin
      if (cfg_valid && cfg_ready) threshold = cfg_data;
      if (out_tvalid && out_tready) begin
        got_status = out_tdata[OUT_STATUS_LO +: STATUS_W];
        got_offset = out_tdata[OUT_OFFSET_LO +: STAMP_W];
        if (due_results.size() == 0) begin
          report("result word with nothing due", '0, got_offset);
        end else begin
          want = due_results.pop_front();
          if (got_status != want.track_status) begin
            report("track_status", STAMP_W'(want.track_status), STAMP_W'(got_status));
          end
          if (out_tuser != want.offset_valid) begin
            report("offset_valid", STAMP_W'(want.offset_valid), STAMP_W'(out_tuser));
          end
          if (got_offset != want.offset_us) report("offset_us", want.offset_us, got_offset);
          checked_count++;
          if (want.offset_valid) offset_hits++;
        end
      end
      if (in_tvalid && in_tready) begin
        step_tracks(in_tuser, in_tdata[IN_TA_LO +: SEL_W], in_tdata[IN_TB_LO +: SEL_W],
                    in_tdata[IN_STAMP_LO +: STAMP_W], in_tdata[IN_LEVEL_LO +: LEVEL_W], want);
        due_results.push_back(want);
      end
      outstanding <= due_results.size();
    end
  end

endmodule

// File: verif/multi_track_level_sync_detector_test.sv
// top of the multi-track level sync detector test: clock, reset, threshold
// writes, directed and random level and query words, receiver stalls, verdict
// depends on mtlsd_pkg, mtlsd_checker and the detector rtl
module multi_track_level_sync_detector_test
  import mtlsd_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT      = 400000;
  localparam int PHASES     = 6;
  localparam int PHASE_SIZE = 175;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [LEVEL_W-1:0]    cfg_data;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;

  int error_count;
  int outstanding;
  int checked_count;
  int offset_hits;

  int                 cycle_count;
  int                 burst_left;
  int                 writes_sent;
  int                 queries_sent;
  int                 settings_used;
  logic [STAMP_W-1:0] stamp_clock;

  multi_track_level_sync_detector dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  mtlsd_checker chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser),
    .error_count  (error_count),
    .outstanding  (outstanding),
    .checked_count(checked_count),
    .offset_hits  (offset_hits)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results still due", LIMIT, outstanding);
    $display("multi_track_level_sync_detector_test: FAIL");
    $finish;
  end

  // receiver stall pattern, switching among four styles
  initial begin
    int mode;
    int left;
    int tick;
    out_tready = 1'b0;
    mode = 0;
    left = 0;
    tick = 0;
    forever begin
      @(posedge clk);
      if (left == 0) begin
        mode = $urandom_range(3);
        left = $urandom_range(300, 40);
      end
      left--;
      tick++;
      case (mode)
        0: begin
          out_tready <= 1'b1;
        end
        1: begin
          out_tready <= 1'($urandom_range(1));
        end
        2: begin
          out_tready <= (tick % 29) < 17;
        end
        default: begin
          out_tready <= ($urandom_range(7) != 0);
        end
      endcase
    end
  end

  task automatic write_threshold(logic [LEVEL_W-1:0] value);
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  task automatic send_word(logic fn, logic [SEL_W-1:0] ta, logic [SEL_W-1:0] tb,
                           logic [STAMP_W-1:0] stamp, logic [LEVEL_W-1:0] lvl);
    logic [IN_DATA_W-1:0] w;
    w = '0;
    w[IN_TA_LO +: SEL_W]      = ta;
    w[IN_TB_LO +: SEL_W]      = tb;
    w[IN_STAMP_LO +: STAMP_W] = stamp;
    w[IN_LEVEL_LO +: LEVEL_W] = lvl;
    in_tdata  <= w;
    in_tuser  <= fn;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (fn == FN_WRITE) writes_sent++;
    else queries_sent++;
    // bursts with random gaps, now and then a long run with no gap
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(12, 1)) @(posedge clk);
      burst_left = ($urandom_range(9) == 0) ? $urandom_range(300, 100) : $urandom_range(30, 0);
    end
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [LEVEL_W-1:0] pick_level(logic [LEVEL_W-1:0] thr);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 8) return NO_LEVEL;
    if (r < 18) return $urandom;
    if (r < 54) begin
      if (thr < 64 || r < 30) return $urandom_range(thr, 0);
      return thr - $urandom_range(63, 0);
    end
    if (thr == NO_LEVEL) return $urandom;
    if (thr > NO_LEVEL - 64 || r > 85) return $urandom_range(NO_LEVEL, thr + 1);
    return thr + 1 + $urandom_range(63, 0);
  endfunction

  task automatic random_word(logic [LEVEL_W-1:0] thr);
    logic [SEL_W-1:0] ta;
    logic [SEL_W-1:0] tb;
    ta = SEL_W'($urandom_range(7));
    tb = ($urandom_range(3) == 0) ? ta : SEL_W'($urandom_range(7));
    if ($urandom_range(99) < 35) begin
      send_word(FN_QUERY, ta, tb, {$urandom, $urandom}, $urandom);
    end else begin
      if ($urandom_range(19) == 0) stamp_clock = {$urandom, $urandom};
      else stamp_clock += $urandom_range(40000, 1);
      send_word(FN_WRITE, ta, tb, stamp_clock, pick_level(thr));
    end
  endtask

  initial begin
    logic [LEVEL_W-1:0] phase_thr [PHASES];
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    in_tuser      = FN_WRITE;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    burst_left    = 0;
    writes_sent   = 0;
    queries_sent  = 0;
    settings_used = 0;
    stamp_clock   = {$urandom, $urandom};
    rst_n         = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_threshold(32'd1000);
    // fresh tracks, first writes with no previous level, crossings both ways
    send_word(FN_QUERY, 3'd0, 3'd7, '1, '1);
    send_word(FN_WRITE, 3'd0, 3'd0, 64'd10, 32'd500);
    send_word(FN_WRITE, 3'd0, 3'd0, 64'd20, 32'd2000);
    send_word(FN_WRITE, 3'd0, 3'd0, 64'd30, 32'd3000);
    send_word(FN_WRITE, 3'd7, 3'd0, 64'h8000_0000_0000_0000, 32'd0);
    send_word(FN_WRITE, 3'd7, 3'd0, 64'h8000_0000_0000_0001, NO_LEVEL);
    send_word(FN_WRITE, 3'd7, 3'd0, 64'd5, 32'd0);
    send_word(FN_QUERY, 3'd0, 3'd7, '0, '0);
    send_word(FN_QUERY, 3'd7, 3'd0, '1, '1);
    send_word(FN_WRITE, 3'd3, 3'd7, 64'h7fff_ffff_ffff_ffff, 32'd1000);
    send_word(FN_WRITE, 3'd3, 3'd7, 64'h7fff_ffff_ffff_ffff, 32'd1001);
    send_word(FN_WRITE, 3'd3, 3'd7, '1, 32'd1000);
    send_word(FN_WRITE, 3'd4, 3'd0, 64'd100, 32'hffff_fffe);
    send_word(FN_WRITE, 3'd4, 3'd0, 64'd200, 32'd0);
    send_word(FN_QUERY, 3'd3, 3'd4, '0, '0);
    send_word(FN_QUERY, 3'd0, 3'd3, '0, '0);
    send_word(FN_QUERY, 3'd3, 3'd3, '0, '0);
    send_word(FN_QUERY, 3'd5, 3'd5, '0, '0);
    send_word(FN_QUERY, 3'd0, 3'd5, '0, '0);
    send_word(FN_WRITE, 3'd5, 3'd7, 64'd300, 32'd5);
    send_word(FN_WRITE, 3'd5, 3'd7, 64'd400, 32'd4);
    send_word(FN_QUERY, 3'd5, 3'd0, '0, '0);
    drain_results();

    phase_thr[0] = $urandom;
    phase_thr[1] = '0;
    phase_thr[2] = NO_LEVEL;
    phase_thr[3] = $urandom_range(255);
    phase_thr[4] = NO_LEVEL - 1;
    phase_thr[5] = $urandom;
    for (int p = 0; p < PHASES; p++) begin
      write_threshold(phase_thr[p]);
      for (int n = 0; n < PHASE_SIZE; n++) random_word(phase_thr[p]);
      drain_results();
    end
    repeat (8) @(posedge clk);

    $display("covered %0d level writes and %0d track queries over %0d threshold settings",
             writes_sent, queries_sent, settings_used);
    $display("%0d result words compared, %0d of them with a valid offset",
             checked_count, offset_hits);
    if (error_count == 0 && outstanding == 0) begin
      $display("multi_track_level_sync_detector_test: PASS");
    end else begin
      $display("multi_track_level_sync_detector_test: FAIL");
    end
    $finish;
  end

endmodule
